// ----- rtl/audio_level_meter_peak_hold_defines.svh -----
// Assertion macros for the level meter checker.
`ifndef AUDIO_LEVEL_METER_PEAK_HOLD_DEFINES_SVH
`define AUDIO_LEVEL_METER_PEAK_HOLD_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ALM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/alm_pkg.sv -----
// Types and constants for the audio level meter.
package alm_pkg;

   localparam int LEVEL_W     = 16;
   localparam int CFG_W       = 16;
   localparam int AGE_W       = 16;
   localparam int COUNT_W     = 13;
   localparam int COEF_W      = 17;
   localparam int TAB_W       = 16;
   localparam int COEF_STAGES = 13;
   localparam int NUM_STAGES  = COEF_STAGES + 1;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] MAX_BLOCK  = 13'd4096;
   localparam logic [COEF_W-1:0]  COEF_ONE   = 17'h10000;
   localparam logic [AGE_W-1:0]   AGE_MAX    = 16'hFFFF;
   localparam logic [TAB_W-1:0]   ROUND_HALF = 16'h8000;

   localparam logic [CFG_W-1:0] DECAY_RATE_RST  = 16'd66;
   localparam logic [CFG_W-1:0] HOLD_TIME_RST   = 16'd1000;
   localparam logic [CFG_W-1:0] REDRAW_INTV_RST = 16'd100;

   // round(65536 * 0.9^(2^b / 256)) for bit b of the sample count
   typedef logic [TAB_W-1:0] pow_tab_type [COEF_STAGES];
   localparam pow_tab_type POW_TAB = '{
      16'd65509, 16'd65482, 16'd65428, 16'd65321, 16'd65106, 16'd64679, 16'd63832,
      16'd62173, 16'd58982, 16'd53084, 16'd42998, 16'd28211, 16'd12144
   };

   typedef enum logic [1:0] {
      OP_LEVEL = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      REG_DECAY_RATE      = 2'd0,
      REG_HOLD_TIME       = 2'd1,
      REG_REDRAW_INTERVAL = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] decay_rate;
      logic [CFG_W-1:0] hold_time_ms;
      logic [CFG_W-1:0] redraw_interval_ms;
   } cfg_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [LEVEL_W-1:0] rms;
      logic [LEVEL_W-1:0] peak;
      logic [COUNT_W-1:0] count;
      logic [COEF_W-1:0]  coef;
   } item_type;

endpackage

// ----- rtl/audio_level_meter_peak_hold.sv -----
// Top level of the audio level meter with linear peak decay and peak hold.
//
// Input channel req_*: one item per handshake. req_tuser carries the opcode
// (level update, one millisecond tick, clear); req_tdata carries the block
// RMS level, the block peak level and the sample count.
// Result channel rsp_*: exactly one item per input item, in order, carrying
// the smoothed RMS level, the decaying peak and the hold level after the
// input item has been applied.
// The smoothing coefficient 0.9^(n/256) is built one sample count bit
// per stage over a 13-stage multiply pipeline behind the input register;
// the state update then happens in the final stage, whose state
// registers are the result.
// Throughput: one item per cycle while results are taken.
// Stalls: the pipeline collapses bubbles; with rsp_tready low it keeps
// taking items until every stage is full, then drops req_tready. A waiting
// result holds steady until taken.
// Reset clears all levels, ages and the redraw counter, empties the
// pipeline and loads the register defaults (decay 66, hold 1000 ms,
// redraw 100 ms). No clearing pass is needed.
// Registers (csr_*): decay_rate at 0x0, hold_time_ms at 0x4,
// redraw_interval_ms at 0x8, 16 bits each; write only while idle.
module audio_level_meter_peak_hold
   import alm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,  // rms_in[15:0], peak_in[31:16], sample_count[44:32]
   input  logic [1:0]            req_tuser,  // opcode[1:0]
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,  // rms_level[15:0], decayed_peak[31:16], hold_level[47:32]
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type            cfg;
   logic               pipe_valid;
   logic               core_ready;
   item_type           pipe_item;
   logic [LEVEL_W-1:0] rms_level, decayed_peak, hold_level;

   alm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // coefficient built here so the state stage needs only one multiply for the RMS smoothing
   alm_coef_pipe u_coef_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_opcode (opcode_type'(req_tuser)),
      .in_rms    (req_tdata[15:0]),
      .in_peak   (req_tdata[31:16]),
      .in_count  (req_tdata[44:32]),
      .out_valid (pipe_valid),
      .out_ready (core_ready),
      .out_item  (pipe_item)
   );

   alm_meter_core u_meter_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (pipe_valid),
      .in_ready    (core_ready),
      .in_item     (pipe_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rms     (rms_level),
      .out_decayed (decayed_peak),
      .out_hold    (hold_level)
   );

   assign rsp_tdata = {hold_level, decayed_peak, rms_level};

endmodule

// ----- rtl/alm_csr.sv -----
// APB register file for decay rate, hold time and redraw interval.
module alm_csr
   import alm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_DECAY_RATE:      cfg_in.decay_rate         = pwdata[CFG_W-1:0];
            REG_HOLD_TIME:       cfg_in.hold_time_ms       = pwdata[CFG_W-1:0];
            REG_REDRAW_INTERVAL: cfg_in.redraw_interval_ms = pwdata[CFG_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DECAY_RATE:      prdata = CSR_DATA_W'(cfg_ff.decay_rate);
         REG_HOLD_TIME:       prdata = CSR_DATA_W'(cfg_ff.hold_time_ms);
         REG_REDRAW_INTERVAL: prdata = CSR_DATA_W'(cfg_ff.redraw_interval_ms);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_rate         <= DECAY_RATE_RST;
         cfg_ff.hold_time_ms       <= HOLD_TIME_RST;
         cfg_ff.redraw_interval_ms <= REDRAW_INTV_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/alm_coef_pipe.sv -----
// Input register and smoothing coefficient pipeline, one count bit per stage.
module alm_coef_pipe
   import alm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  opcode_type         in_opcode,
   input  logic [LEVEL_W-1:0] in_rms,
   input  logic [LEVEL_W-1:0] in_peak,
   input  logic [COUNT_W-1:0] in_count,
   output logic               out_valid,
   input  logic               out_ready,
   output item_type           out_item
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   ready_chain;
   item_type              data_ff [NUM_STAGES];
   item_type              data_in [NUM_STAGES];
   item_type              load_item;

   // apply bit b of the count: c = (c * T[b] + 1/2) >> 16
   function automatic item_type apply_bit(input item_type it, input int b);
      logic [COEF_W+TAB_W-1:0] prod;
      item_type                res;
      res  = it;
      prod = (COEF_W+TAB_W)'(it.coef) * (COEF_W+TAB_W)'(POW_TAB[b])
           + (COEF_W+TAB_W)'(ROUND_HALF);
      if (it.count[b])
         res.coef = prod[COEF_W+TAB_W-1:TAB_W];
      return res;
   endfunction

   always_comb begin
      load_item.opcode = in_opcode;
      load_item.rms    = in_rms;
      load_item.peak   = in_peak;
      load_item.count  = (in_count > MAX_BLOCK) ? MAX_BLOCK : in_count;
      load_item.coef   = COEF_ONE;
   end

   // a stage can load when empty or when its contents move on
   always_comb begin
      ready_chain[NUM_STAGES] = out_ready;
      for (int s = NUM_STAGES - 1; s >= 0; s--)
         ready_chain[s] = !valid_ff[s] || ready_chain[s+1];
   end

   always_comb begin
      valid_in = valid_ff;
      for (int s = 0; s < NUM_STAGES; s++)
         data_in[s] = data_ff[s];
      if (ready_chain[0]) begin
         valid_in[0] = in_valid;
         data_in[0]  = load_item;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
         if (ready_chain[s]) begin
            valid_in[s] = valid_ff[s-1];
            data_in[s]  = apply_bit(data_ff[s-1], s - 1);
         end
      end
   end

   assign in_ready  = ready_chain[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_item  = data_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STAGES; s++)
         data_ff[s] <= data_in[s];
   end

endmodule

// ----- rtl/alm_meter_core.sv -----
// Meter state update; the state registers double as the result register.
module alm_meter_core
   import alm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  item_type           in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [LEVEL_W-1:0] out_rms,
   output logic [LEVEL_W-1:0] out_decayed,
   output logic [LEVEL_W-1:0] out_hold
);

   localparam int PROD_W = LEVEL_W + COEF_W + 2;
   localparam int ACC_W  = PROD_W + 1;

   logic               out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0] smoothed_ff, smoothed_in;
   logic [LEVEL_W-1:0] captured_ff, captured_in;
   logic [LEVEL_W-1:0] decaying_ff, decaying_in;
   logic [LEVEL_W-1:0] held_ff, held_in;
   logic [AGE_W-1:0]   peak_age_ff, peak_age_in;
   logic [AGE_W-1:0]   hold_age_ff, hold_age_in;
   logic [CFG_W-1:0]   redraw_ff, redraw_in;

   logic                     accept;
   logic signed [LEVEL_W:0]  rms_diff;
   logic signed [PROD_W-1:0] rms_prod;
   logic [ACC_W-1:0]         rms_acc;
   logic [AGE_W-1:0]         peak_age_inc, hold_age_inc;
   logic [CFG_W:0]           redraw_inc;
   logic                     redraw_fire;
   logic [2*CFG_W-1:0]       decay_amt;
   logic                     decay_left;

   assign in_ready = !out_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // s*c + r*(1-c) = r + (s - r)*c, one signed multiply
   assign rms_diff = $signed({1'b0, smoothed_ff}) - $signed({1'b0, in_item.rms});
   assign rms_prod = rms_diff * $signed({1'b0, in_item.coef});
   assign rms_acc  = {{(ACC_W-2*LEVEL_W){1'b0}}, in_item.rms, {LEVEL_W{1'b0}}}
                   + {rms_prod[PROD_W-1], rms_prod}
                   + ACC_W'(ROUND_HALF);

   assign peak_age_inc = (peak_age_ff == AGE_MAX) ? peak_age_ff : peak_age_ff + 1'b1;
   assign hold_age_inc = (hold_age_ff == AGE_MAX) ? hold_age_ff : hold_age_ff + 1'b1;
   assign redraw_inc   = {1'b0, redraw_ff} + 1'b1;
   assign redraw_fire  = redraw_inc >= {1'b0, cfg.redraw_interval_ms};

   assign decay_amt  = (2*CFG_W)'(cfg.decay_rate) * (2*CFG_W)'(peak_age_inc);
   assign decay_left = (decay_amt[2*CFG_W-1:LEVEL_W] == '0)
                    && (decay_amt[LEVEL_W-1:0] < captured_ff);

   always_comb begin
      smoothed_in = smoothed_ff;
      captured_in = captured_ff;
      decaying_in = decaying_ff;
      held_in     = held_ff;
      peak_age_in = peak_age_ff;
      hold_age_in = hold_age_ff;
      redraw_in   = redraw_ff;
      if (accept) begin
         case (in_item.opcode)
            OP_LEVEL: begin
               smoothed_in = rms_acc[2*LEVEL_W-1:LEVEL_W];
               if (in_item.peak > decaying_ff) begin
                  captured_in = in_item.peak;
                  decaying_in = in_item.peak;
                  peak_age_in = '0;
               end
               if (in_item.peak > held_ff) begin
                  held_in     = in_item.peak;
                  hold_age_in = '0;
               end
            end
            OP_TICK: begin
               peak_age_in = peak_age_inc;
               hold_age_in = hold_age_inc;
               redraw_in   = redraw_inc[CFG_W-1:0];
               if (redraw_fire) begin
                  redraw_in   = '0;
                  decaying_in = decay_left ?
                                captured_ff - decay_amt[LEVEL_W-1:0] : '0;
                  if (hold_age_inc > cfg.hold_time_ms)
                     held_in = '0;
               end
            end
            OP_CLEAR: begin
               smoothed_in = '0;
               captured_in = '0;
            end
            default: begin
               smoothed_in = smoothed_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (accept)
         out_valid_in = 1'b1;
      else if (out_ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   assign out_valid   = out_valid_ff;
   assign out_rms     = smoothed_ff;
   assign out_decayed = decaying_ff;
   assign out_hold    = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         smoothed_ff  <= '0;
         captured_ff  <= '0;
         decaying_ff  <= '0;
         held_ff      <= '0;
         peak_age_ff  <= '0;
         hold_age_ff  <= '0;
         redraw_ff    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         smoothed_ff  <= smoothed_in;
         captured_ff  <= captured_in;
         decaying_ff  <= decaying_in;
         held_ff      <= held_in;
         peak_age_ff  <= peak_age_in;
         hold_age_ff  <= hold_age_in;
         redraw_ff    <= redraw_in;
      end
   end

endmodule

// ----- rtl/alm_checker.sv -----
// Port-level checker for the level meter, bound to the top level.
`include "audio_level_meter_peak_hold_defines.svh"

module alm_checker
   import alm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [47:0]           rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   logic csr_wr;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // nothing comes out right after reset
   `ALM_ASSERT_NOW(a_no_rsp_after_reset, $past(reset), !rsp_tvalid, "result valid after reset")

   // a waiting result holds
   `ALM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // an open result side never blocks the input side
   `ALM_ASSERT_NOW(a_ready_flow, rsp_tready, req_tready, "input blocked while results drain")

   // a written register reads back on the following cycle
   `ALM_ASSERT_NOW(a_csr_readback, $past(csr_wr) && !$past(reset) && csr_paddr == $past(csr_paddr) && $past(csr_paddr[CSR_ADDR_W-1:2]) <= REG_REDRAW_INTERVAL, csr_prdata == CSR_DATA_W'($past(csr_pwdata[CFG_W-1:0])), "register readback mismatch")

endmodule

bind audio_level_meter_peak_hold alm_checker u_alm_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench for the audio level meter with peak decay and hold.
`timescale 1ns / 100ps

module tb_top
   import alm_pkg::*;
();

   // opcode 3 has no enum member; the meter must ignore it and report levels
   localparam logic [1:0] OP_SPARE = 2'd3;

   // round(65536 * 0.9^(2^b / 256)), one factor per sample count bit
   localparam bit [15:0] SMOOTH_STEP [13] = '{
      16'd65509, 16'd65482, 16'd65428, 16'd65321, 16'd65106, 16'd64679, 16'd63832,
      16'd62173, 16'd58982, 16'd53084, 16'd42998, 16'd28211, 16'd12144
   };
   localparam bit [12:0] BLOCK_LIMIT  = 13'd4096;
   localparam bit [15:0] AGE_LIMIT    = 16'hFFFF;
   localparam int        ITEMS_PER_PHASE = 220;
   localparam int        NUM_PHASES   = 8;
   localparam int        DRAIN_CYCLES = 20;
   localparam int        CYCLE_LIMIT  = 400000;

   // Tracks the meter state and the levels each accepted item should report.
   class level_meter_scoreboard;
      bit [15:0]   decay_rate, hold_time_ms, redraw_interval_ms;
      bit [15:0]   smoothed_rms, captured_peak, decaying_peak, held_peak;
      bit [15:0]   peak_age, hold_age;
      int unsigned redraw_count;
      bit [47:0]   expected_levels[$];
      int unsigned errors;

      function new();
         decay_rate         = 16'd66;
         hold_time_ms       = 16'd1000;
         redraw_interval_ms = 16'd100;
         smoothed_rms  = '0;
         captured_peak = '0;
         decaying_peak = '0;
         held_peak     = '0;
         peak_age      = '0;
         hold_age      = '0;
         redraw_count  = 0;
         errors        = 0;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void set_register(reg_index_type idx, bit [15:0] value);
         case (idx)
            REG_DECAY_RATE:      decay_rate = value;
            REG_HOLD_TIME:       hold_time_ms = value;
            REG_REDRAW_INTERVAL: redraw_interval_ms = value;
            default: ;
         endcase
      endfunction

      // 0.9^(n/256) in Q1.16, built bit by bit from the rounded table
      function bit [16:0] smoothing_coef(bit [12:0] n);
         bit [33:0] c;
         c = 34'h10000;
         for (int b = 0; b < 13; b++)
            if (n[b]) c = (c * SMOOTH_STEP[b] + 34'h8000) >> 16;
         return c[16:0];
      endfunction

      function void note_input(logic [1:0] op, logic [15:0] rms_in, logic [15:0] peak_in,
                               logic [12:0] count);
         bit [12:0] n;
         bit [16:0] c;
         bit [39:0] mix;
         bit [31:0] drop;
         case (op)
            OP_LEVEL: begin
               n = (count > BLOCK_LIMIT) ? BLOCK_LIMIT : count;
               c = smoothing_coef(n);
               mix = smoothed_rms * c + rms_in * (17'h10000 - c) + 40'h8000;
               smoothed_rms = mix[31:16];
               if (peak_in > decaying_peak) begin
                  captured_peak = peak_in;
                  decaying_peak = peak_in;
                  peak_age = '0;
               end
               if (peak_in > held_peak) begin
                  held_peak = peak_in;
                  hold_age = '0;
               end
            end
            OP_TICK: begin
               if (peak_age != AGE_LIMIT) peak_age++;
               if (hold_age != AGE_LIMIT) hold_age++;
               redraw_count++;
               // an interval of zero evaluates on every tick
               if (redraw_count >= redraw_interval_ms) begin
                  redraw_count = 0;
                  drop = decay_rate * peak_age;
                  decaying_peak = (drop < captured_peak) ? captured_peak - drop[15:0] : '0;
                  if (hold_age > hold_time_ms) held_peak = '0;
               end
            end
            OP_CLEAR: begin
               smoothed_rms  = '0;
               captured_peak = '0;
            end
            default: ;
         endcase
         expected_levels.push_back({held_peak, decaying_peak, smoothed_rms});
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 30) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(logic [47:0] levels);
         bit [47:0] want;
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("result %h with no item pending", levels));
            return;
         end
         want = expected_levels.pop_front();
         if (levels[15:0] !== want[15:0])
            report_mismatch($sformatf("rms_level %h, want %h", levels[15:0], want[15:0]));
         if (levels[31:16] !== want[31:16])
            report_mismatch($sformatf("decayed_peak %h, want %h",
                                      levels[31:16], want[31:16]));
         if (levels[47:32] !== want[47:32])
            report_mismatch($sformatf("hold_level %h, want %h",
                                      levels[47:32], want[47:32]));
      endtask
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and DUT hookup. Every input starts at a known value.
   // ---------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;   // rms_in[15:0], peak_in[31:16], sample_count[44:32]
   logic [1:0]            req_tuser = OP_LEVEL;  // opcode[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;  // rms_level[15:0], decayed_peak[31:16], hold_level[47:32]
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // percentages of cycles in which the sender idles / the receiver stalls
   int sender_idle_pct = 0;
   int stall_pct = 0;

   level_meter_scoreboard meter = new();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   audio_level_meter_peak_hold i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Receiver: one fresh ready decision per cycle; stall_pct 0 means always ready.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Result monitor. Signals are read at the edge, before any NBA lands, so
   // these are the values that made the handshake.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) meter.check_result(rsp_tdata);

   // Watchdog: a hung handshake or a lost result ends here.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[audio_level_meter_peak_hold] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Drivers. All tasks start and end right after a rising edge. tvalid is
   // left high after an item so back-to-back items never lower and raise it
   // in the same step; idle cycles and the drain lower it.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [1:0] op, input logic [15:0] rms_in,
                            input logic [15:0] peak_in, input logic [12:0] count);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, count, peak_in, rms_in};
      do @(posedge clock); while (!req_tready);
      meter.note_input(op, rms_in, peak_in, count);
   endtask

   // Stop sending, wait for every outstanding level report, then let the
   // pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (meter.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle until pready. psel stays
   // up between back-to-back writes; write_settings drops it at the end.
   task automatic write_register(input reg_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      meter.set_register(idx, value);
   endtask

   task automatic write_settings(input logic [15:0] decay, input logic [15:0] hold,
                                 input logic [15:0] redraw);
      wait_idle();
      write_register(REG_DECAY_RATE, decay);
      write_register(REG_HOLD_TIME, hold);
      write_register(REG_REDRAW_INTERVAL, redraw);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   // per-phase register settings; phases 3 and 6 draw theirs at random
   localparam logic [15:0] PHASE_DECAY  [NUM_PHASES] =
      '{16'd66, 16'd0, 16'd65535, 16'd0, 16'd300, 16'd1500, 16'd0, 16'd5};
   localparam logic [15:0] PHASE_HOLD   [NUM_PHASES] =
      '{16'd1000, 16'd0, 16'd65535, 16'd0, 16'd50, 16'd10, 16'd0, 16'd65535};
   localparam logic [15:0] PHASE_REDRAW [NUM_PHASES] =
      '{16'd100, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd3, 16'd0, 16'd1};

   initial begin : stimulus
      logic [1:0]  op;
      logic [15:0] rms_in, peak_in;
      logic [12:0] count;
      int          pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: register defaults still in force ---
      send_item(OP_LEVEL, 16'hFFFF, 16'hFFFF, 13'd4096);  // full scale, largest block
      send_item(OP_LEVEL, 16'h0000, 16'h0000, 13'd0);     // zero count keeps the RMS
      send_item(OP_LEVEL, 16'd12345, 16'd100, 13'h1FFF); // count clamps to 4096
      send_item(OP_LEVEL, 16'hFFFF, 16'h0000, 13'd4097);
      send_item(OP_LEVEL, 16'hAAAA, 16'h5555, 13'd1);
      send_item(OP_SPARE, 16'h5555, 16'hAAAA, 13'h1555); // unused opcode: no change
      send_item(OP_LEVEL, 16'h5555, 16'hAAAA, 13'h0AAA);
      send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 13'h1FFF); // decay and hold survive
      send_item(OP_LEVEL, 16'd40000, 16'd30000, 13'd256);
      send_item(OP_TICK, 16'h0000, 16'h0000, 13'd0);

      // --- directed: zero redraw interval evaluates every tick, short hold ---
      write_settings(16'd65535, 16'd2, 16'd0);
      send_item(OP_TICK, 16'h0000, 16'h0000, 13'd0);      // steep decay drives peak to 0
      send_item(OP_LEVEL, 16'd9000, 16'd1000, 13'd16);    // recapture, hold unchanged
      send_item(OP_TICK, 16'h0000, 16'h0000, 13'd0);
      send_item(OP_TICK, 16'h0000, 16'h0000, 13'd0);      // hold age still past 2: stays cleared
      send_item(OP_LEVEL, 16'd100, 16'd500, 13'd4095);
      send_item(OP_CLEAR, 16'h0000, 16'h0000, 13'd0);
      send_item(OP_TICK, 16'h0000, 16'h0000, 13'd0);      // captured peak zero after clear
      send_item(OP_SPARE, 16'hFFFF, 16'h0000, 13'd0);

      // --- random phases: each a register setting and an idling pattern ---
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 3 || p == 6)
            write_settings(16'($urandom_range(1, 3000)), 16'($urandom_range(0, 300)),
                           16'($urandom_range(1, 40)));
         else
            write_settings(PHASE_DECAY[p], PHASE_HOLD[p], PHASE_REDRAW[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 73; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 73; end
            default: begin sender_idle_pct = 34; stall_pct = 34; end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // once, hold the sender back until the meter has caught up
            if (p == 2 && i == ITEMS_PER_PHASE / 2) wait_idle();
            // ticks dominate so decay evaluations and hold expiry actually happen
            pick = $urandom_range(99);
            if (pick < 50)      op = OP_TICK;
            else if (pick < 85) op = OP_LEVEL;
            else if (pick < 93) op = OP_CLEAR;
            else                op = OP_SPARE;
            rms_in = 16'($urandom_range(16'hFFFF));
            case ($urandom_range(3))
               0: peak_in = 16'($urandom_range(16'hFFFF));
               1: peak_in = 16'($urandom_range(1023));
               2: peak_in = 16'($urandom_range(16'hFFFF, 16'd64000));
               default: peak_in = '0;
            endcase
            pick = $urandom_range(9);
            if (pick < 6)       count = 13'($urandom_range(4096));
            else if (pick == 6) count = 13'($urandom_range(13'h1FFF, 13'd4097));
            else if (pick == 7) count = '0;
            else                count = 13'd1 << $urandom_range(12);
            send_item(op, rms_in, peak_in, count);
         end
      end

      wait_idle();
      if (meter.errors == 0 && meter.pending() == 0)
         $display("[audio_level_meter_peak_hold] OK");
      else
         $display("[audio_level_meter_peak_hold] ERROR");
      $finish;
   end

endmodule
